/* design/dfc_pkg.sv */
// ---------------------------------------------------------------------------
// Dark frame calibration package
// Shared widths, field codes, register indexes and divider interface types.
// ---------------------------------------------------------------------------
package dfc_pkg;

  // Field widths fixed by the item format.
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 20;
  localparam int PIX_W   = 16;
  localparam int CFG_A_W = 1;

  // Parameter defaults.
  localparam int NUM_PIXELS_DEF = 1048576;
  localparam int MAX_FRAMES_DEF = 255;

  // Largest pixel value, which also marks a saturated sum.
  localparam logic [PIX_W-1:0] PIX_MAX = 16'hFFFF;

  // Mode codes of an input item.
  localparam logic [MODE_W-1:0] MODE_CAPTURE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FINALIZE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CORRECT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] CFG_BAD_LIMIT  = 1'd0;
  localparam logic [CFG_A_W-1:0] CFG_FILL_VALUE = 1'd1;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] dividend;
  } dfc_div_req_t;

  // Status and quotient from the shared divider.
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quotient;
  } dfc_div_stat_t;

endpackage

/* design/dfc_div.sv */
// ---------------------------------------------------------------------------
// Shared serial divider
// Restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module dfc_div import dfc_pkg::*; #(
  parameter int DVW = 21
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dfc_div_req_t  req,
  input  logic [DVW-1:0] divisor,
  output dfc_div_stat_t stat
);

  localparam int SW = $clog2(IDX_W + 1);

  logic           run_r;
  logic           done_r;
  logic [SW-1:0]  step_r;
  logic [DVW-1:0] div_r;
  logic [DVW-1:0] rem_r;
  logic [IDX_W-1:0] quo_r;

  logic [DVW:0] trial;
  logic [DVW:0] diff;
  logic         fits;

  // One trial subtraction of the shifted partial remainder.
  assign trial = {rem_r, quo_r[IDX_W-1]};
  assign fits  = (trial >= {1'b0, div_r});
  assign diff  = trial - {1'b0, div_r};

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == SW'(IDX_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      div_r <= divisor;
      rem_r <= '0;
      quo_r <= req.dividend;
    end else if (run_r) begin
      rem_r <= fits ? diff[DVW-1:0] : trial[DVW-1:0];
      quo_r <= {quo_r[IDX_W-2:0], fits};
    end
  end

  assign stat.done     = done_r;
  assign stat.quotient = quo_r;

endmodule

/* design/dark_frame_calibration_core.sv */
// Capture, correct and zero-count finalize items pass through the read and execute states to the result.
// A saturated finalize adds the finalize state; a dividing finalize adds the divide and finalize states,
// at one of 20 quotient bits a cycle. A non-power-of-two pixel count below 2^20 adds the modulo state.
// One item at a time: busy stays high until its result strobe.
// Synchronous reset clears control, frame count and configuration registers, not the store or payload.
// The result is shown for one cycle; the receiver cannot stall it.
// ---------------------------------------------------------------------------
// Dark frame calibration core
// Per-pixel black store with capture, finalize with bad pixel fill, and correct.
// ---------------------------------------------------------------------------
module dark_frame_calibration_core import dfc_pkg::*; #(
  parameter int NUM_PIXELS = NUM_PIXELS_DEF,
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [IDX_W-1:0]   in_pixel_index,
  input  logic [PIX_W-1:0]   in_pixel_value,
  input  logic               in_last_of_frame,
  output logic               out_valid,
  output logic [IDX_W-1:0]   out_index_out,
  output logic [PIX_W-1:0]   out_value_out,
  output logic               out_bad_flag,
  output logic               out_last_out,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]   cfg_wdata
);

  localparam int  AW  = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int  CW  = $clog2(MAX_FRAMES + 1);
  localparam int  DVW = CW;
  localparam bit  POS_DIV = (NUM_PIXELS < (1 << IDX_W)) &&
                            ((NUM_PIXELS & (NUM_PIXELS - 1)) != 0);

  // Reciprocal of the pixel count: quotient = (index * RECIP) >> PSH is exact
  // for every 20-bit index when the shift is IDX_W plus the address width.
  localparam int  RW  = IDX_W + 2;
  localparam int  MW  = IDX_W + RW;
  localparam int  QW  = (AW < IDX_W) ? (RW - AW) : 2;
  localparam int  PSH = MW - QW;
  localparam logic [63:0] RECIP = POS_DIV ?
      (((64'd1 << PSH) + 64'(NUM_PIXELS) - 64'd1) / 64'(NUM_PIXELS)) : 64'd0;
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MOD  = 6'b000010,
    ST_READ = 6'b000100,
    ST_EXEC = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [PIX_W-1:0]  pix_r, pix_nxt;
  logic              last_r, last_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [QW-1:0]     quo_r, quo_nxt;
  logic [PIX_W-1:0]  mean_r, mean_nxt;
  logic [PIX_W-1:0]  rdata_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic              present_r, present_nxt;
  logic [PIX_W-1:0]  bad_limit_r, fill_r;

  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_index_r, out_index_nxt;
  logic [PIX_W-1:0]  out_value_r, out_value_nxt;
  logic              out_bad_r, out_bad_nxt;
  logic              out_last_r, out_last_nxt;

  logic              mem_we;
  logic [PIX_W-1:0]  mem_wdata;
  logic [PIX_W-1:0]  mem_r [NUM_PIXELS];

  dfc_div_req_t      div_req;
  dfc_div_stat_t     div_stat;
  logic [DVW-1:0]    div_divisor;

  logic [MW-1:0]     recip_prod;
  logic [IDX_W-1:0]  mod_prod;

  logic [PIX_W:0]    sum_wide;
  logic [PIX_W-1:0]  cap_val;
  logic [PIX_W-1:0]  corr_val;
  logic              fin_bad;

  // Shared divider for the frame mean.
  dfc_div #(.DVW(DVW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (div_divisor),
    .stat    (div_stat)
  );

  // Address reduction modulo the pixel count: quotient at accept, remainder next cycle.
  assign recip_prod = MW'(in_pixel_index) * RECIP_M;
  assign mod_prod   = IDX_W'(quo_r) * IDX_W'(NUM_PIXELS);

  // Black store with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[pos_r] <= mem_wdata;
    end
    rdata_r <= mem_r[pos_r];
  end

  // Per-mode values from the stored black level.
  assign sum_wide = {1'b0, rdata_r} + {1'b0, pix_r};
  assign cap_val  = (count_r == '0) ? pix_r :
                    (sum_wide[PIX_W] ? PIX_MAX : sum_wide[PIX_W-1:0]);
  assign corr_val = !present_r ? pix_r :
                    ((pix_r > rdata_r) ? (pix_r - rdata_r) : '0);
  assign fin_bad  = (mean_r > bad_limit_r);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    idx_nxt       = idx_r;
    pix_nxt       = pix_r;
    last_nxt      = last_r;
    pos_nxt       = pos_r;
    quo_nxt       = quo_r;
    mean_nxt      = mean_r;
    count_nxt     = count_r;
    present_nxt   = present_r;
    out_valid_nxt = 1'b0;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_bad_nxt   = out_bad_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_wdata     = '0;
    div_req       = '0;
    div_divisor   = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          idx_nxt  = in_pixel_index;
          pix_nxt  = in_pixel_value;
          last_nxt = in_last_of_frame;
          if (POS_DIV) begin
            quo_nxt   = recip_prod[MW-1:PSH];
            state_nxt = ST_MOD;
          end else begin
            pos_nxt   = AW'(in_pixel_index);
            state_nxt = ST_READ;
          end
        end
      end
      ST_MOD: begin
        pos_nxt   = AW'(idx_r - mod_prod);
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        out_index_nxt = idx_r;
        out_last_nxt  = last_r;
        out_bad_nxt   = 1'b0;
        state_nxt     = ST_IDLE;
        case (mode_r)
          MODE_CAPTURE: begin
            mem_we        = 1'b1;
            mem_wdata     = cap_val;
            present_nxt   = 1'b1;
            if (last_r && (count_r < CW'(MAX_FRAMES))) begin
              count_nxt = count_r + 1'b1;
            end
            out_valid_nxt = 1'b1;
            out_value_nxt = cap_val;
          end
          MODE_FINALIZE: begin
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              out_value_nxt = rdata_r;
            end else if (rdata_r != PIX_MAX) begin
              // Rounded mean: (sum + count/2) / count.
              div_req.start    = 1'b1;
              div_req.dividend = IDX_W'(rdata_r) + IDX_W'(count_r >> 1);
              div_divisor      = DVW'(count_r);
              state_nxt        = ST_DIV;
            end else begin
              mean_nxt  = rdata_r;
              state_nxt = ST_FIN;
            end
          end
          MODE_CORRECT: begin
            out_valid_nxt = 1'b1;
            out_value_nxt = corr_val;
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_value_nxt = pix_r;
          end
        endcase
      end
      ST_DIV: begin
        if (div_stat.done) begin
          mean_nxt  = div_stat.quotient[PIX_W-1:0];
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Bad pixel test and store of the averaged black level.
        mem_we        = 1'b1;
        mem_wdata     = fin_bad ? fill_r : mean_r;
        if (last_r) begin
          count_nxt = '0;
        end
        out_valid_nxt = 1'b1;
        out_index_nxt = idx_r;
        out_value_nxt = fin_bad ? fill_r : mean_r;
        out_bad_nxt   = fin_bad;
        out_last_nxt  = last_r;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      present_r   <= 1'b0;
      out_valid_r <= 1'b0;
      bad_limit_r <= PIX_MAX;
      fill_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BAD_LIMIT:  bad_limit_r <= cfg_wdata;
          CFG_FILL_VALUE: fill_r      <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    idx_r       <= idx_nxt;
    pix_r       <= pix_nxt;
    last_r      <= last_nxt;
    pos_r       <= pos_nxt;
    quo_r       <= quo_nxt;
    mean_r      <= mean_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_bad_r   <= out_bad_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_index_out = out_index_r;
  assign out_value_out = out_value_r;
  assign out_bad_flag  = out_bad_r;
  assign out_last_out  = out_last_r;

endmodule

/* design/dfc_checker.sv */
// ---------------------------------------------------------------------------
// Dark frame calibration port checker
// Checks the command handshake and result strobe timing seen at the ports.
// ---------------------------------------------------------------------------
module dfc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // An accepted item makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result strobe only follows a busy cycle.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // The block is free again while its result is shown.
  a_result_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy held during result strobe");

  // Busy ends only together with the item's result.
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("busy ended without a result");

endmodule

bind dark_frame_calibration_core dfc_checker u_dfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
